[src/rpm_plausibility_filter_top_defines.svh]
// Assertion helpers for the RPM plausibility filter.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef RPM_PLAUSIBILITY_FILTER_TOP_DEFINES_SVH
`define RPM_PLAUSIBILITY_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpm plausibility filter check failed");

// Next-cycle implication, checked outside reset.
`define RPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpm plausibility filter check failed");

`endif

[src/rpf_pkg.sv]
package rpf_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Sample status codes.
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STOP     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_JUMP     = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_CIRCUMFERENCE = 1'b0;
  localparam logic CFG_TIMEOUT       = 1'b1;

  // Commands for the speed register at the end of the pipeline.
  localparam logic [1:0] SPD_HOLD = 2'd0;
  localparam logic [1:0] SPD_ZERO = 2'd1;
  localparam logic [1:0] SPD_LOAD = 2'd2;

  // Valid rpm window in 9.4 fixed point, and the scaled windows below and above it.
  localparam logic [17:0] RPM_LOW     = 18'd1600;
  localparam logic [17:0] RPM_HIGH    = 18'd8000;
  localparam logic [17:0] RPM_LOW_LO  = 18'd160;
  localparam logic [17:0] RPM_HIGH_LO = 18'd800;
  localparam logic [17:0] RPM_LOW_HI  = 18'd16000;
  localparam logic [17:0] RPM_HIGH_HI = 18'd80000;

  // Reciprocals: x/10 = (x*RECIP10)>>20, x/15 = (x*RECIP15)>>23, x/25 = (x*RECIP25)>>27.
  // Each is exact over the operand range used here.
  localparam logic [16:0] RECIP10 = 17'd104858;
  localparam logic [19:0] RECIP15 = 20'd559241;
  localparam logic [22:0] RECIP25 = 23'd5368710;

  localparam logic [16:0] SPEED_MAX     = 17'd131071;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

[src/rpm_plausibility_filter_top.sv]
// RPM plausibility filter: qualifies rpm samples and tracks rpm, frequency and speed.
// An accepted beat passes the stage 1, stage 2 and output registers in turn.
// Throughput: one item per cycle while out_stall_i is low; the three-stage pipeline (normalize,
// multiply, speed reciprocal) holds three items; while the result waits, it accepts until full.
// Reset (rst_ni low, async) clears valids, filter state, speed, circumference; timeout 1000 ms.
`include "rpm_plausibility_filter_top_defines.svh"

module rpm_plausibility_filter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [18:0] rpm_value_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [12:0]        rpm_now_o,
  output logic [15:0]        frequency_hz_o,
  output logic [16:0]        road_speed_o,
  output logic               running_o,
  output logic [2:0]         sample_status_o
);

  // Configuration registers.
  logic [15:0] circ_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q    <= '0;
      timeout_q <= rpf_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpf_pkg::CFG_CIRCUMFERENCE: circ_q <= cfg_data_i;
        rpf_pkg::CFG_TIMEOUT:       timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage loads when empty or when it drains forward.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_ready, s2_ready, s1_ready, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;

  // Filter state.
  logic [12:0] last_valid_q, last_valid_d;
  logic [12:0] cur_rpm_q, cur_rpm_d;
  logic        running_q, running_d;
  logic [31:0] last_time_q, last_time_d;

  // Stage 0: range check and normalization of the reported reading.
  logic        stop_smp;
  logic [17:0] mag;
  logic        in_mid, in_lo, in_hi;
  logic [33:0] div_prod;
  logic [12:0] norm_rpm;
  logic        norm_ok;
  logic        jump;
  logic [31:0] elapsed;
  logic [2:0]  status_d;
  logic [1:0]  cmd_d;

  assign stop_smp = rpm_value_i[18] || (rpm_value_i == '0);
  assign mag      = rpm_value_i[17:0];
  assign in_mid   = (mag >= rpf_pkg::RPM_LOW) && (mag <= rpf_pkg::RPM_HIGH);
  assign in_lo    = (mag >= rpf_pkg::RPM_LOW_LO) && (mag <= rpf_pkg::RPM_HIGH_LO);
  assign in_hi    = (mag >= rpf_pkg::RPM_LOW_HI) && (mag <= rpf_pkg::RPM_HIGH_HI);
  assign div_prod = {17'd0, mag[16:0]} * {17'd0, rpf_pkg::RECIP10};
  assign norm_ok  = in_mid || in_lo || in_hi;

  always_comb begin
    if (in_mid) begin
      norm_rpm = mag[12:0];
    end else if (in_lo) begin
      norm_rpm = {mag[9:0], 3'b000} + {2'b00, mag[9:0], 1'b0};
    end else begin
      norm_rpm = div_prod[32:20];
    end
  end

  // A jump check is skipped until a first reading has been accepted.
  assign jump = (last_valid_q != '0) &&
                (({norm_rpm, 1'b0} < {1'b0, last_valid_q}) ||
                 ({1'b0, norm_rpm} > {last_valid_q, 1'b0}));

  // Wrap-safe elapsed time since the last accepted or stop sample.
  assign elapsed = now_ms_i - last_time_q;

  always_comb begin
    last_valid_d = last_valid_q;
    cur_rpm_d    = cur_rpm_q;
    running_d    = running_q;
    last_time_d  = last_time_q;
    status_d     = rpf_pkg::ST_NONE;
    cmd_d        = rpf_pkg::SPD_HOLD;
    case (operation_i)
      rpf_pkg::OP_SAMPLE: begin
        if (stop_smp) begin
          cur_rpm_d   = '0;
          running_d   = 1'b0;
          last_time_d = now_ms_i;
          status_d    = rpf_pkg::ST_STOP;
          cmd_d       = rpf_pkg::SPD_ZERO;
        end else if (!norm_ok) begin
          status_d = rpf_pkg::ST_RANGE;
        end else if (jump) begin
          status_d = rpf_pkg::ST_JUMP;
        end else begin
          last_valid_d = norm_rpm;
          cur_rpm_d    = norm_rpm;
          running_d    = 1'b1;
          last_time_d  = now_ms_i;
          status_d     = rpf_pkg::ST_ACCEPTED;
          cmd_d        = rpf_pkg::SPD_LOAD;
        end
      end
      rpf_pkg::OP_TICK: begin
        if (running_q && (elapsed > {16'd0, timeout_q})) begin
          cur_rpm_d = '0;
          running_d = 1'b0;
          cmd_d     = rpf_pkg::SPD_ZERO;
        end
      end
      rpf_pkg::OP_CLEAR: begin
        cur_rpm_d = '0;
        running_d = 1'b0;
        cmd_d     = rpf_pkg::SPD_ZERO;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= '0;
      cur_rpm_q    <= '0;
      running_q    <= 1'b0;
      last_time_q  <= '0;
    end else if (in_accept) begin
      last_valid_q <= last_valid_d;
      cur_rpm_q    <= cur_rpm_d;
      running_q    <= running_d;
      last_time_q  <= last_time_d;
    end
  end

  // Stage 1 registers.
  logic [12:0] s1_rpm_q;
  logic        s1_run_q;
  logic [2:0]  s1_status_q;
  logic [1:0]  s1_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_rpm_q    <= cur_rpm_d;
      s1_run_q    <= running_d;
      s1_status_q <= status_d;
      s1_cmd_q    <= cmd_d;
    end
  end

  // Stage 1: frequency (rpm*256/60 = rpm*64/15) and rpm times circumference.
  logic [38:0] freq_prod;
  logic [28:0] circ_prod;

  assign freq_prod = {20'd0, s1_rpm_q, 6'd0} * {19'd0, rpf_pkg::RECIP15};
  assign circ_prod = {16'd0, s1_rpm_q} * {13'd0, circ_q};

  // Stage 2 registers.
  logic [12:0] s2_rpm_q;
  logic [15:0] s2_freq_q;
  logic [28:0] s2_prod_q;
  logic        s2_run_q;
  logic [2:0]  s2_status_q;
  logic [1:0]  s2_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_rpm_q    <= s1_rpm_q;
      s2_freq_q   <= freq_prod[38:23];
      s2_prod_q   <= circ_prod;
      s2_run_q    <= s1_run_q;
      s2_status_q <= s1_status_q;
      s2_cmd_q    <= s1_cmd_q;
    end
  end

  // Stage 2: speed = rpm*circ*3/12800, as ((p*3)>>9)/25, saturated.
  logic [30:0] prod3;
  logic [21:0] prod_sh;
  logic [44:0] spd_prod;
  logic [17:0] spd_raw;
  logic [16:0] spd_sat;
  logic [16:0] speed_q;

  assign prod3    = {2'd0, s2_prod_q} + {1'b0, s2_prod_q, 1'b0};
  assign prod_sh  = prod3[30:9];
  assign spd_prod = {23'd0, prod_sh} * {22'd0, rpf_pkg::RECIP25};
  assign spd_raw  = spd_prod[44:27];
  assign spd_sat  = (spd_raw > {1'b0, rpf_pkg::SPEED_MAX}) ? rpf_pkg::SPEED_MAX : spd_raw[16:0];

  // Output register; the speed register lives here and follows each beat's command.
  logic [12:0] out_rpm_q;
  logic [15:0] out_freq_q;
  logic        out_run_q;
  logic [2:0]  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      speed_q     <= '0;
    end else begin
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
      if (s2_valid_q && out_ready) begin
        case (s2_cmd_q)
          rpf_pkg::SPD_LOAD: speed_q <= spd_sat;
          rpf_pkg::SPD_ZERO: speed_q <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_ready) begin
      out_rpm_q    <= s2_rpm_q;
      out_freq_q   <= s2_freq_q;
      out_run_q    <= s2_run_q;
      out_status_q <= s2_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rpm_now_o       = out_rpm_q;
  assign frequency_hz_o  = out_freq_q;
  assign road_speed_o    = speed_q;
  assign running_o       = out_run_q;
  assign sample_status_o = out_status_q;

  // The wheel can only be running with a nonzero rpm inside the valid window.
  `RPF_ASSERT(a_run_has_rpm, running_q, cur_rpm_q != '0)
  `RPF_ASSERT(a_rpm_window, cur_rpm_q != '0,
              ({5'd0, cur_rpm_q} >= rpf_pkg::RPM_LOW) && ({5'd0, cur_rpm_q} <= rpf_pkg::RPM_HIGH))
  // An accepted sample leaves rpm and the last valid reading equal.
  `RPF_ASSERT_NEXT(a_accept_updates, in_accept && (status_d == rpf_pkg::ST_ACCEPTED),
                   running_q && (last_valid_q == cur_rpm_q))
  // A delivered result that reports running carries a nonzero rpm.
  `RPF_ASSERT(a_out_run_rpm, out_valid_q && out_run_q, out_rpm_q != '0)

endmodule

[sim/rpm_filter_checker.sv]
module rpm_filter_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic signed [18:0] rpm_value_i,
  input  logic [31:0]        now_ms_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [12:0]        rpm_now_i,
  input  logic [15:0]        frequency_hz_i,
  input  logic [16:0]        road_speed_i,
  input  logic               running_i,
  input  logic [2:0]         sample_status_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] rpm;
    logic [15:0] freq;
    logic [16:0] speed;
    logic        running;
    logic [2:0]  status;
  } wheel_readout_t;

  // Shadow copy of the filter state and its registers.
  logic [15:0] circ_q;
  logic [15:0] timeout_q;
  logic [12:0] good_rpm;
  logic [12:0] cur_rpm;
  logic [16:0] cur_speed;
  logic        turning;
  logic [31:0] last_seen_ms;

  wheel_readout_t wheel_readouts_q[$];
  wheel_readout_t oldest;
  int unsigned    fail_count = 0;

  assign mismatches_o = fail_count;

  function automatic void halt_wheel();
    cur_rpm   = '0;
    cur_speed = '0;
    turning   = 1'b0;
  endfunction

  // Brings a positive reading into the 100..500 rpm window, or returns zero.
  function automatic logic [12:0] scale_reading(input int r);
    if (r >= int'(rpf_pkg::RPM_LOW) && r <= int'(rpf_pkg::RPM_HIGH)) return 13'(r);
    if (r >= int'(rpf_pkg::RPM_LOW_LO) && r <= int'(rpf_pkg::RPM_HIGH_LO)) return 13'(r * 10);
    if (r >= int'(rpf_pkg::RPM_LOW_HI) && r <= int'(rpf_pkg::RPM_HIGH_HI)) return 13'(r / 10);
    return '0;
  endfunction

  // Applies one input beat to the shadow state and returns the readout it causes.
  function automatic wheel_readout_t advance_wheel(input logic [1:0] op, input int r,
                                                   input logic [31:0] now);
    wheel_readout_t res;
    logic [12:0]    scaled;
    logic [31:0]    elapsed;
    logic [63:0]    prod;
    res.status = rpf_pkg::ST_NONE;
    case (op)
      rpf_pkg::OP_SAMPLE: begin
        if (r <= 0) begin
          halt_wheel();
          last_seen_ms = now;
          res.status = rpf_pkg::ST_STOP;
        end else begin
          scaled = scale_reading(r);
          if (scaled == '0) begin
            res.status = rpf_pkg::ST_RANGE;
          end else if (good_rpm != '0 &&
                       (32'(scaled) * 32'd2 < 32'(good_rpm) ||
                        32'(scaled) > 32'(good_rpm) * 32'd2)) begin
            res.status = rpf_pkg::ST_JUMP;
          end else begin
            prod         = (64'(scaled) * 64'(circ_q) * 64'd3) / 64'd12800;
            good_rpm     = scaled;
            cur_rpm      = scaled;
            cur_speed    = (prod > 64'(rpf_pkg::SPEED_MAX)) ? rpf_pkg::SPEED_MAX : prod[16:0];
            turning      = 1'b1;
            last_seen_ms = now;
            res.status   = rpf_pkg::ST_ACCEPTED;
          end
        end
      end
      rpf_pkg::OP_TICK: begin
        // Elapsed time is taken modulo 2^32, so a wrapped clock still works.
        elapsed = now - last_seen_ms;
        if (turning && elapsed > 32'(timeout_q)) halt_wheel();
      end
      rpf_pkg::OP_CLEAR: begin
        halt_wheel();
      end
      default: begin
      end
    endcase
    res.rpm     = cur_rpm;
    res.freq    = 16'((32'(cur_rpm) * 32'd256) / 32'd60);
    res.speed   = cur_speed;
    res.running = turning;
    return res;
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Predict on each input beat, compare on each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q        = '0;
      timeout_q     = rpf_pkg::TIMEOUT_RESET;
      good_rpm      = '0;
      cur_rpm       = '0;
      cur_speed     = '0;
      turning       = 1'b0;
      last_seen_ms  = '0;
      wheel_readouts_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpf_pkg::CFG_CIRCUMFERENCE: circ_q = cfg_data_i;
          rpf_pkg::CFG_TIMEOUT:       timeout_q = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i)
        wheel_readouts_q.push_back(advance_wheel(operation_i, rpm_value_i, now_ms_i));
      if (out_valid_i && !out_stall_i) begin
        if (wheel_readouts_q.size() == 0) begin
          $display("%0t: result beat expected none, actual rpm %0d status %0d",
                   $time, rpm_now_i, sample_status_i);
          fail_count++;
        end else begin
          oldest = wheel_readouts_q.pop_front();
          check_field("rpm_now", oldest.rpm, rpm_now_i);
          check_field("frequency_hz", oldest.freq, frequency_hz_i);
          check_field("road_speed", oldest.speed, road_speed_i);
          check_field("running", oldest.running, running_i);
          check_field("sample_status", oldest.status, sample_status_i);
        end
      end
      outstanding_o <= wheel_readouts_q.size();
    end
  end

endmodule

[sim/tb_rpm_plausibility_filter_top.sv]
module tb_rpm_plausibility_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PHASE_COUNT     = 5;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         operation_i;
  logic signed [18:0] rpm_value_i;
  logic [31:0]        now_ms_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [12:0]        rpm_now_o;
  logic [15:0]        frequency_hz_o;
  logic [16:0]        road_speed_o;
  logic               running_o;
  logic [2:0]         sample_status_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // Stimulus bookkeeping: system time, timeout in force and the rpm we aim near.
  logic [31:0] clock_ms = 32'd100;
  int unsigned tmo_copy = 1000;
  int unsigned aim_rpm = 4000;
  int unsigned burst_left = 0;

  rpm_plausibility_filter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .rpm_value_i    (rpm_value_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rpm_now_o      (rpm_now_o),
    .frequency_hz_o (frequency_hz_o),
    .road_speed_o   (road_speed_o),
    .running_o      (running_o),
    .sample_status_o(sample_status_o)
  );

  rpm_filter_checker filter_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .rpm_value_i    (rpm_value_i),
    .now_ms_i       (now_ms_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rpm_now_i      (rpm_now_o),
    .frequency_hz_i (frequency_hz_o),
    .road_speed_i   (road_speed_o),
    .running_i      (running_o),
    .sample_status_i(sample_status_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver switches to a new random stall density after each random span.
  initial begin
    int unsigned stall_pct;
    int unsigned span;
    out_stall_i <= 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Drives one input beat and returns once it is taken; a gap may follow a burst.
  task automatic push_item(input logic [1:0] op, input int r, input logic [31:0] now);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rpm_value_i <= r[18:0];
    now_ms_i    <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic sample_reading(input int r);
    clock_ms += 32'd10;
    push_item(rpf_pkg::OP_SAMPLE, r, clock_ms);
  endtask

  // Holds the sender off until every result is back and the pipeline is empty.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] circ, input logic [15:0] tmo);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rpf_pkg::CFG_CIRCUMFERENCE;
    cfg_data_i <= circ;
    @(posedge clk_i);
    cfg_idx_i  <= rpf_pkg::CFG_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tmo_copy = tmo;
  endtask

  // Mostly plausible samples near the last one, plus ticks, clears and noise.
  task automatic random_item();
    int unsigned        pick;
    int unsigned        target;
    int                 r;
    logic signed [18:0] raw;
    logic [31:0]        step;
    pick = $urandom_range(0, 99);
    step = ($urandom_range(0, 99) < 3) ? $urandom() : $urandom_range(0, 2 * tmo_copy + 2);
    clock_ms += step;
    raw = 19'($urandom());
    r = raw;
    if ($urandom_range(0, 99) == 0) wait_idle();
    if (pick < 60) begin
      if ($urandom_range(0, 9) == 0) aim_rpm = $urandom_range(1600, 8000);
      target = (aim_rpm * $urandom_range(55, 195)) / 100;
      if (target < 1600) target = 1600;
      if (target > 8000) target = 8000;
      aim_rpm = target;
      case ($urandom_range(0, 2))
        0:       r = target;
        1:       r = target / 10;
        default: r = target * 10 + $urandom_range(0, 9);
      endcase
      push_item(rpf_pkg::OP_SAMPLE, r, clock_ms);
    end else if (pick < 66) begin
      push_item(rpf_pkg::OP_SAMPLE, -int'($urandom_range(0, 262144)), clock_ms);
    end else if (pick < 72) begin
      push_item(rpf_pkg::OP_SAMPLE, r, clock_ms);
    end else if (pick < 92) begin
      push_item(rpf_pkg::OP_TICK, r, clock_ms);
    end else if (pick < 97) begin
      push_item(rpf_pkg::OP_CLEAR, r, clock_ms);
    end else begin
      push_item(OP_UNUSED, r, clock_ms);
    end
  endtask

  initial begin
    logic [15:0] circ;
    logic [15:0] tmo;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= rpf_pkg::CFG_CIRCUMFERENCE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    operation_i <= rpf_pkg::OP_SAMPLE;
    rpm_value_i <= '0;
    now_ms_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: boundaries of every scaling window,
    // the first sample, jumps at exactly half and double, timeouts and wrap.
    push_item(rpf_pkg::OP_TICK, 0, 32'd5);
    push_item(OP_UNUSED, 262143, 32'd6);
    sample_reading(0);
    sample_reading(-262144);
    sample_reading(262143);
    sample_reading(1);
    sample_reading(159);
    sample_reading(160);
    sample_reading(8000);
    sample_reading(3200);
    sample_reading(1600);
    sample_reading(800);
    sample_reading(16000);
    sample_reading(80000);
    sample_reading(80001);
    sample_reading(15999);
    sample_reading(801);
    sample_reading(8001);
    sample_reading(16009);
    push_item(rpf_pkg::OP_TICK, 0, clock_ms + 32'd1000);
    push_item(rpf_pkg::OP_TICK, 0, clock_ms + 32'd1001);
    clock_ms = 32'hFFFF_FFE6;
    sample_reading(1600);
    push_item(rpf_pkg::OP_TICK, 0, 32'd984);
    push_item(rpf_pkg::OP_TICK, 0, 32'd985);
    clock_ms = 32'd985;
    sample_reading(3200);
    push_item(rpf_pkg::OP_CLEAR, 0, clock_ms);
    push_item(OP_UNUSED, -1, 32'hFFFF_FFFF);

    // Random phases, each under its own register setting.
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          circ = 16'hFFFF;
          tmo  = 16'd1;
        end
        1: begin
          circ = 16'h0000;
          tmo  = 16'd0;
        end
        2: begin
          circ = 16'h2000;
          tmo  = 16'hFFFF;
        end
        default: begin
          circ = 16'($urandom());
          tmo  = 16'($urandom_range(1, 5000));
        end
      endcase
      set_config(circ, tmo);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/rpf_pkg.sv
src/rpm_plausibility_filter_top.sv
sim/rpm_filter_checker.sv
sim/tb_rpm_plausibility_filter_top.sv
